// ===== design/mipmap_downsample_2x2_assert.svh =====
// Assertion macros for the 2x2 mipmap downsampler
`ifndef MIPMAP_DOWNSAMPLE_2X2_ASSERT_SVH
`define MIPMAP_DOWNSAMPLE_2X2_ASSERT_SVH
// Implication checked every clock edge, muted during reset.
`define MD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define MD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/mds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_pkg
// Shared types and constants of the 2x2 mipmap downsampler.
// ----------------------------------------------------------------------------
package mds_pkg;
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned AddrW    = $clog2(MaxWidth);
  localparam int unsigned DimW     = 12;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LAYERS = 2'd2,
    CFG_MODE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_BOX    = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_ALPHA  = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_NORM,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch pixel, update counters and row store
    logic read_rows; // register row store outputs
    logic calc;      // form sums
    logic norm_start;
    logic out_load;  // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;      // current item produces a result
    logic normal;    // result needs normalization
    logic norm_done;
  } sts_t;
endpackage

// ===== design/mds_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_norm
// Iterative normal encoder: per component, 17 steps of a square-root style
// search for q = floor(|s| * 2^15 / sqrt(S)), then 128 +- (127*q)>>15.
// ----------------------------------------------------------------------------
module mds_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [10:0] s0_i,
  input  logic signed [10:0] s1_i,
  input  logic signed [10:0] s2_i,
  output logic               done_o,
  output logic [7:0]         v0_o,
  output logic [7:0]         v1_o,
  output logic [7:0]         v2_o
);
  import mds_pkg::*;

  // |s| <= 512, S <= 3*2^18
  logic signed [10:0] s_q [3];
  logic [20:0]  sq_q;
  logic [1:0]   comp_q;
  logic [4:0]   bit_q;
  logic [16:0]  q_q;
  logic         busy_q;
  logic [1:0]   phase_q;   // 0 compare, 1 mult t*t, 2 mult by S, 3 write back
  logic [33:0]  tt_q;
  logic [7:0]   v_q [3];

  logic [9:0]   mag;
  logic [49:0]  num;
  logic [16:0]  t;
  logic [54:0]  prod;
  logic [23:0]  m127;
  logic [7:0]   m;

  always_comb begin
    mag  = s_q[comp_q][10] ? 10'(-s_q[comp_q]) : s_q[comp_q][9:0];
    num  = 50'(mag * mag) << 30;
    t    = q_q | (17'd1 << bit_q);
    prod = 55'(tt_q) * 55'(sq_q);
    m127 = 24'(q_q) * 24'd127;
    m    = 8'(m127 >> 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_o  <= 1'b0;
      phase_q <= 2'd0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 2'd1;
      end else if (busy_q) begin
        unique case (phase_q)
          2'd1: phase_q <= 2'd2;
          2'd2: phase_q <= 2'd0;
          2'd0: phase_q <= (bit_q == 5'd0) ? 2'd3 : 2'd1;
          2'd3: begin
            if (comp_q == 2'd2) begin
              busy_q  <= 1'b0;
              done_o  <= 1'b1;
              phase_q <= 2'd0;
            end else begin
              phase_q <= 2'd1;
            end
          end
        endcase
      end
    end
  end

  // payload / loop registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q[0] <= s0_i;
      s_q[1] <= s1_i;
      s_q[2] <= s2_i;
      sq_q   <= 21'(s0_i * s0_i) + 21'(s1_i * s1_i) + 21'(s2_i * s2_i);
      comp_q <= 2'd0;
      bit_q  <= 5'd16;
      q_q    <= '0;
    end else if (busy_q) begin
      unique case (phase_q)
        2'd1: tt_q <= 34'(t) * 34'(t);
        2'd0: begin
          if (prod <= 55'(num)) q_q <= t;
          if (bit_q != 5'd0) bit_q <= bit_q - 5'd1;
        end
        2'd3: begin
          v_q[comp_q] <= s_q[comp_q][10] ? 8'(8'd128 - m) : 8'(8'd128 + m);
          if (comp_q != 2'd2) comp_q <= comp_q + 2'd1;
          bit_q <= 5'd16;
          q_q   <= '0;
        end
        default: ;
      endcase
    end
  end

  assign v0_o = v_q[0];
  assign v1_o = v_q[1];
  assign v2_o = v_q[2];
endmodule

// ===== design/mds_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_datapath
// Counters, row store, left pixel, box sums, normal encoder and output register.
// ----------------------------------------------------------------------------
module mds_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mds_pkg::cmd_t       cmd_i,
  output mds_pkg::sts_t       sts_o,
  input  logic                cfg_wr_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [11:0]         cfg_data_i,
  input  logic [7:0]          pix_r_i,
  input  logic [7:0]          pix_g_i,
  input  logic [7:0]          pix_b_i,
  input  logic [7:0]          pix_a_i,
  output logic [7:0]          out_r_o,
  output logic [7:0]          out_g_o,
  output logic [7:0]          out_b_o,
  output logic [7:0]          out_a_o,
  output logic                last_of_pass_o
);
  import mds_pkg::*;

  logic [11:0] width_q, height_q, layers_q;
  logic [1:0]  mode_q;
  logic [11:0] col_q, row_q, layer_q;
  logic [31:0] left_q;
  logic [31:0] store [MaxWidth];
  logic [31:0] cur_q, bl_q, pl_q, pr_q, rl_q, rr_q;
  logic [11:0] x_q, y_q, z_q;
  logic        emit_q;
  logic [9:0]  sum_q [4];
  logic [31:0] out_q;
  logic        last_q, lastc_q;

  logic [11:0] w, h, d, mip_w, last_x, last_y;
  logic        wide, tall, emit, zero_vec;
  logic [31:0] cur;
  logic [AddrW-1:0] ra_r, ra_l;
  logic signed [10:0] s [3];
  logic        norm_done;
  logic [7:0]  nv0, nv1, nv2;

  function automatic logic [11:0] clampd(input logic [11:0] v);
    if (v == 12'd0) return 12'd1;
    return (v > 12'(MaxWidth)) ? 12'(MaxWidth) : v;
  endfunction

  always_comb begin
    w      = clampd(width_q);
    h      = clampd(height_q);
    d      = clampd(layers_q);
    mip_w  = (w >> 1) != 12'd0 ? (w >> 1) : 12'd1;
    wide   = w >= 12'd2;
    tall   = h >= 12'd2;
    last_x = wide ? 12'((mip_w << 1) - 12'd1) : 12'd0;
    last_y = tall ? 12'((h >> 1 << 1) - 12'd1) : 12'd0;
    cur    = {pix_a_i, pix_b_i, pix_g_i, pix_r_i};
    emit   = (col_q < w) && (row_q < h)
             && (wide ? col_q[0] : col_q == 12'd0)
             && (tall ? row_q[0] : row_q == 12'd0);
    ra_r   = col_q[AddrW-1:0];
    ra_l   = AddrW'(col_q - 12'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd1; height_q <= 12'd1; layers_q <= 12'd1;
      mode_q  <= MODE_BOX;
      col_q <= '0; row_q <= '0; layer_q <= '0;
      left_q <= '0;
      emit_q <= 1'b0;
    end else if (cfg_wr_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_LAYERS: layers_q <= cfg_data_i;
        CFG_MODE:   mode_q   <= cfg_data_i[1:0];
      endcase
      col_q <= '0; row_q <= '0; layer_q <= '0;
    end else if (cmd_i.accept) begin
      left_q <= cur;
      emit_q <= emit;
      if (col_q + 12'd1 >= w) begin
        col_q <= '0;
        if (row_q + 12'd1 >= h) begin
          row_q   <= '0;
          layer_q <= (layer_q + 12'd1 >= d) ? 12'd0 : layer_q + 12'd1;
        end else begin
          row_q <= row_q + 12'd1;
        end
      end else begin
        col_q <= col_q + 12'd1;
      end
    end
  end

  // row store: two read ports, one write port, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (col_q < w && row_q < h && tall && !row_q[0]) store[ra_r] <= cur;
      rr_q <= store[ra_r];
      rl_q <= store[ra_l];
      cur_q <= cur;
      bl_q  <= wide ? left_q : cur;
      x_q <= col_q; y_q <= row_q; z_q <= layer_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_rows) begin
      pr_q <= tall ? rr_q : cur_q;
      pl_q <= tall ? (wide ? rl_q : rr_q) : bl_q;
    end
    if (cmd_i.calc) begin
      for (int k = 0; k < 4; k++) begin
        sum_q[k] <= 10'(pl_q[8*k +: 8]) + 10'(pr_q[8*k +: 8])
                  + 10'(bl_q[8*k +: 8]) + 10'(cur_q[8*k +: 8]);
      end
      lastc_q <= (x_q == last_x) && (y_q == last_y)
                 && (mode_q == MODE_ALPHA || z_q == 12'(d - 12'd1));
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) s[k] = 11'(sum_q[k]) - 11'sd508;
    zero_vec = (s[0] == 11'sd0) && (s[1] == 11'sd0) && (s[2] == 11'sd0);
  end

  mds_norm u_norm (
    .clk_i, .rst_ni,
    .start_i (cmd_i.norm_start),
    .s0_i (s[0]), .s1_i (s[1]), .s2_i (s[2]),
    .done_o (norm_done),
    .v0_o (nv0), .v1_o (nv1), .v2_o (nv2)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (mode_e'(mode_q))
        MODE_ALPHA:  out_q <= {4{mip_w[7:0]}};
        MODE_NORMAL: out_q <= zero_vec ? 32'hFFFF_BFBF : {8'hFF, nv2, nv1, nv0};
        default: begin
          out_q <= {sum_q[3][9:2], sum_q[2][9:2], sum_q[1][9:2], sum_q[0][9:2]};
        end
      endcase
      last_q <= lastc_q;
    end
  end

  assign sts_o.emit      = emit_q && !(mode_q == MODE_ALPHA && z_q != 12'd0);
  assign sts_o.normal    = (mode_q == MODE_NORMAL) && !zero_vec;
  assign sts_o.norm_done = norm_done;

  assign out_r_o = out_q[7:0];
  assign out_g_o = out_q[15:8];
  assign out_b_o = out_q[23:16];
  assign out_a_o = out_q[31:24];
  assign last_of_pass_o = last_q;
endmodule

// ===== design/mds_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_ctrl
// Sequencer: accept, read store, sum, optional normalize, present result.
// ----------------------------------------------------------------------------
module mds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mds_pkg::cmd_t cmd_o,
  input  mds_pkg::sts_t sts_i
);
  import mds_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = sts_i.emit ? ST_CALC : ST_IDLE;
      ST_CALC: state_d = ST_NORM;
      ST_NORM: if (!sts_i.normal || sts_i.norm_done) state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ST_NORM: first cycle starts the encoder when needed
  logic started_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= (state_q == ST_NORM);
    end
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: cmd_o.accept = in_valid_i;
      ST_READ: cmd_o.read_rows = 1'b1;
      ST_CALC: cmd_o.calc = 1'b1;
      ST_NORM: begin
        cmd_o.norm_start = sts_i.normal && !started_q;
        cmd_o.out_load   = !sts_i.normal || sts_i.norm_done;
      end
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== design/mipmap_downsample_2x2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_downsample_2x2
// 2x2 box / normal-map / alpha-contrast mip level generator.
// ----------------------------------------------------------------------------
// One pixel is handled at a time. A pixel that yields no mip output passes
// the accept and read states only; a box or alpha result also passes the
// sum and output-load states and waits for out_ready_i; a normal-map result
// adds the iterative encoder (three components, 17 search steps of t*t, *S
// and compare plus one write-back per component, then the result hand-over).
// The row store is a 2048-entry memory, one write and two registered reads.
// Config writes restart the pass counters; issue them only while idle.
module mipmap_downsample_2x2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pix_r_i,
  input  logic [7:0]  pix_g_i,
  input  logic [7:0]  pix_b_i,
  input  logic [7:0]  pix_a_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_r_o,
  output logic [7:0]  out_g_o,
  output logic [7:0]  out_b_o,
  output logic [7:0]  out_a_o,
  output logic        last_of_pass_o
);
  import mds_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = in_ready && !cfg_valid_i;

  mds_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i && !cfg_valid_i),
    .in_ready_o (in_ready),
    .out_valid_o, .out_ready_i,
    .cmd_o (cmd), .sts_i (sts)
  );

  mds_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .sts_o (sts),
    .cfg_wr_i (cfg_valid_i), .cfg_idx_i (cfg_index_i), .cfg_data_i,
    .pix_r_i, .pix_g_i, .pix_b_i, .pix_a_i,
    .out_r_o, .out_g_o, .out_b_o, .out_a_o, .last_of_pass_o
  );
endmodule

// ===== design/mds_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_checker
// Port-level checks of the downsampler.
// ----------------------------------------------------------------------------
`include "mipmap_downsample_2x2_assert.svh"
module mds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_r_o
);
  // one item in flight: no new input while a result waits
  `MD_ASSERT_IMP(no_in_while_out, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // a result stays valid, with out_r_o stable, until taken
  `MD_ASSERT_NEXT(out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_r_o))
  // accepted input closes the ready window
  `MD_ASSERT_NEXT(ready_drops, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind mipmap_downsample_2x2 mds_checker u_chk (.*);
